[sv/ifsd_pkg.sv]
// ---------------------------------------------------------------------------
// ifsd_pkg
// Shared types and constants for the inclinometer frame sync decoder.
// ---------------------------------------------------------------------------
package ifsd_pkg;

	// Header bytes that open every frame
	localparam logic [7:0] HEADER_FIRST  = 8'h61;
	localparam logic [7:0] HEADER_SECOND = 8'h22;

	// Raw sensor value that stands for zero tilt
	localparam logic [24:0] ANGLE_OFFSET = 25'd3000000;

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int RAW_W   = 24;
	localparam int ANGLE_W = 25;
	localparam int POS_W   = 6;
	localparam int ANGLE_BYTES_W = 48;

	// Sync phase, one-hot
	typedef enum logic [2:0] {
		PH_HUNT    = 3'b001,
		PH_SAW     = 3'b010,
		PH_COLLECT = 3'b100
	} phase_t;

	// Raw angles of a completed frame
	typedef struct packed {
		logic [RAW_W-1:0] x_raw;
		logic [RAW_W-1:0] y_raw;
	} frame_t;

endpackage

[sv/ifsd_sync.sv]
// ---------------------------------------------------------------------------
// ifsd_sync
// Header hunt and frame collection: tracks the sync phase and frame
// position, stores frame bytes 2..7 and flags the last byte of a frame.
// ---------------------------------------------------------------------------
module ifsd_sync #(
	parameter int FRAME_BYTES = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [ifsd_pkg::BYTE_W-1:0] rx_byte,
	output logic                       frame_done,
	output ifsd_pkg::frame_t           frame
);

	localparam logic [ifsd_pkg::POS_W-1:0] LAST_POS = ifsd_pkg::POS_W'(FRAME_BYTES - 1);

	ifsd_pkg::phase_t                       phase_q, phase_nx;
	logic [ifsd_pkg::POS_W-1:0]             pos_q, pos_nx;
	logic [ifsd_pkg::ANGLE_BYTES_W-1:0]     bytes_q, bytes_nx;

	// Drop the current byte into its slot while collecting
	always_comb begin
		bytes_nx = bytes_q;
		if (phase_q == ifsd_pkg::PH_COLLECT) begin
			for (int k = 0; k < 6; k++) begin
				if (pos_q == ifsd_pkg::POS_W'(k + 2)) begin
					bytes_nx[8*k +: 8] = rx_byte;
				end
			end
		end
	end

	assign frame_done  = (phase_q == ifsd_pkg::PH_COLLECT) && (pos_q >= LAST_POS);
	assign frame.y_raw = bytes_nx[23:0];
	assign frame.x_raw = bytes_nx[47:24];

	// Advance the sync phase; an unknown code hunts
	always_comb begin
		phase_nx = ifsd_pkg::PH_HUNT;
		pos_nx   = '0;
		unique case (phase_q)
			ifsd_pkg::PH_COLLECT: begin
				if (!frame_done) begin
					phase_nx = ifsd_pkg::PH_COLLECT;
					pos_nx   = pos_q + 1'b1;
				end
			end
			ifsd_pkg::PH_SAW: begin
				if (rx_byte == ifsd_pkg::HEADER_SECOND) begin
					phase_nx = ifsd_pkg::PH_COLLECT;
					pos_nx   = ifsd_pkg::POS_W'(2);
				end else if (rx_byte == ifsd_pkg::HEADER_FIRST) begin
					phase_nx = ifsd_pkg::PH_SAW;
					pos_nx   = ifsd_pkg::POS_W'(1);
				end
			end
			default: begin
				if (rx_byte == ifsd_pkg::HEADER_FIRST) begin
					phase_nx = ifsd_pkg::PH_SAW;
					pos_nx   = ifsd_pkg::POS_W'(1);
				end
			end
		endcase
	end

	// Hold state until a byte steps through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ifsd_pkg::PH_HUNT;
			pos_q   <= '0;
			bytes_q <= '0;
		end else if (step) begin
			phase_q <= phase_nx;
			pos_q   <= pos_nx;
			bytes_q <= bytes_nx;
		end
	end

endmodule

[sv/ifsd_out.sv]
// ---------------------------------------------------------------------------
// ifsd_out
// Result register: removes the zero-tilt offset from both raw angles and
// holds the result item until the downstream side takes it.
// ---------------------------------------------------------------------------
module ifsd_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ifsd_pkg::frame_t frame,
	output logic             out_free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [55:0]      m_tdata
);

	logic                          valid_q;
	logic [ifsd_pkg::ANGLE_W-1:0]  x_q, y_q;

	assign out_free = !valid_q || m_tready;

	// Track occupancy of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Subtract the offset as the result is loaded
	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= {1'b0, frame.x_raw} - ifsd_pkg::ANGLE_OFFSET;
			y_q <= {1'b0, frame.y_raw} - ifsd_pkg::ANGLE_OFFSET;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'b0, y_q, x_q};

endmodule

[sv/inclinometer_frame_sync_decoder.sv]
// ---------------------------------------------------------------------------
// inclinometer_frame_sync_decoder
// Byte-stream deframer for a dual-axis inclinometer link.
// ---------------------------------------------------------------------------
// Takes one received byte per item and hunts for the header 0x61 0x22,
// sliding one byte on a mismatch. After a header it collects the rest of a
// FRAME_BYTES-long frame and, on its last byte, emits one item with X from
// bytes 5..7 and Y from bytes 2..4 (little-endian, minus 3000000, in units of
// 1e-5 degree). The block accepts one byte every cycle unless a frame's last
// byte waits for the result register. A result is presented once the frame's
// last byte is accepted, is decoded out of the input register and lands in
// the result register. A stalled output holds one result while bytes keep
// flowing until the next frame's last byte reaches the input register, which
// then waits for the result register to free.
module inclinometer_frame_sync_decoder #(
	parameter int FRAME_BYTES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // [24:0] x_angle, [49:25] y_angle, [55:50] zero
);

	logic                         v_s1;
	logic [ifsd_pkg::BYTE_W-1:0]  byte_s1;
	logic                         frame_done;
	ifsd_pkg::frame_t             frame;
	logic                         out_free;
	logic                         advance;
	logic                         load;

	// Move the registered byte on unless its result has nowhere to go
	assign advance  = v_s1 && (!frame_done || out_free);
	assign load     = v_s1 && frame_done && out_free;
	assign s_tready = !v_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	ifsd_sync #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_sync (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (byte_s1),
		.frame_done (frame_done),
		.frame      (frame)
	);

	ifsd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.frame    (frame),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// An accepted byte lands in the input register
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted item missing from input register");

	// A finished frame always shows up at the output
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid)
		else $error("loaded result not presented");

	// An empty input register never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("input stalled while input register empty");

endmodule

[test/tb_inclinometer_frame_sync_decoder.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_inclinometer_frame_sync_decoder
// Self-checking bench for the inclinometer byte-stream deframer.
// ---------------------------------------------------------------------------
// Feeds received bytes with random gaps and output stalls. A byte-level
// decoder in the scoreboard tracks header sync and frame collection, and
// queues the X/Y tilt expected at each frame end. Every decoded item is
// compared against the oldest queued tilt. Directed bytes cover broken and
// doubled headers, a header pattern inside the payload, and the raw angle
// extremes. Random traffic then mixes clean frames with noise.
// ---------------------------------------------------------------------------
module tb_inclinometer_frame_sync_decoder;

	localparam int FRAME_LEN  = 12;
	localparam int RAND_BYTES = 500;
	localparam int CALM_BYTES = 100;
	localparam int TAIL_CYCLES = 20;

	typedef struct {
		logic [ifsd_pkg::ANGLE_W-1:0] x_angle;
		logic [ifsd_pkg::ANGLE_W-1:0] y_angle;
	} tilt_t;

	// Tracks sync and frame collection, and holds tilts not yet seen
	class tilt_scoreboard;
		ifsd_pkg::phase_t                   sync_phase;
		logic [ifsd_pkg::POS_W-1:0]         frame_pos;
		logic [ifsd_pkg::ANGLE_BYTES_W-1:0] angle_bytes;
		tilt_t                              tilt_queue[$];
		int                                 errors;
		int                                 matched;

		function new();
			sync_phase  = ifsd_pkg::PH_HUNT;
			frame_pos   = '0;
			angle_bytes = '0;
			errors      = 0;
			matched     = 0;
		endfunction

		function logic [ifsd_pkg::ANGLE_W-1:0] to_tilt(logic [ifsd_pkg::RAW_W-1:0] raw);
			return {1'b0, raw} - ifsd_pkg::ANGLE_OFFSET;
		endfunction

		function int pending();
			return tilt_queue.size();
		endfunction

		// Advance the decoder by one accepted byte
		function void note_byte(logic [ifsd_pkg::BYTE_W-1:0] rx);
			tilt_t t;
			case (sync_phase)
				ifsd_pkg::PH_COLLECT: begin
					if (frame_pos >= 2 && frame_pos <= 7)
						angle_bytes[8*(frame_pos-2) +: 8] = rx;
					if (frame_pos >= FRAME_LEN - 1) begin
						t.x_angle = to_tilt(angle_bytes[47:24]);
						t.y_angle = to_tilt(angle_bytes[23:0]);
						tilt_queue.push_back(t);
						sync_phase = ifsd_pkg::PH_HUNT;
						frame_pos  = '0;
					end else begin
						frame_pos = frame_pos + 1'b1;
					end
				end
				ifsd_pkg::PH_SAW: begin
					if (rx == ifsd_pkg::HEADER_SECOND) begin
						sync_phase = ifsd_pkg::PH_COLLECT;
						frame_pos  = 6'd2;
					end else if (rx == ifsd_pkg::HEADER_FIRST) begin
						sync_phase = ifsd_pkg::PH_SAW;
						frame_pos  = 6'd1;
					end else begin
						sync_phase = ifsd_pkg::PH_HUNT;
						frame_pos  = '0;
					end
				end
				default: begin
					// any other phase code hunts
					if (rx == ifsd_pkg::HEADER_FIRST) begin
						sync_phase = ifsd_pkg::PH_SAW;
						frame_pos  = 6'd1;
					end else begin
						sync_phase = ifsd_pkg::PH_HUNT;
						frame_pos  = '0;
					end
				end
			endcase
		endfunction

		// Compare one decoded item with the oldest queued tilt
		function void check_result(logic [55:0] data);
			tilt_t t;
			if (tilt_queue.size() == 0) begin
				$error("unexpected item: x_angle %0d y_angle %0d",
					$signed(data[24:0]), $signed(data[49:25]));
				errors++;
				return;
			end
			t = tilt_queue.pop_front();
			if (data[24:0] !== t.x_angle) begin
				$error("x_angle: expected %0d, got %0d",
					$signed(t.x_angle), $signed(data[24:0]));
				errors++;
			end
			if (data[49:25] !== t.y_angle) begin
				$error("y_angle: expected %0d, got %0d",
					$signed(t.y_angle), $signed(data[49:25]));
				errors++;
			end
			matched++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // [24:0] x_angle, [49:25] y_angle, [55:50] zero

	tilt_scoreboard sb;
	bit             calm;
	int             sent;

	inclinometer_frame_sync_decoder #(
		.FRAME_BYTES(FRAME_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Give up after a generous fixed time
	initial begin
		#2ms;
		$display("tb_inclinometer_frame_sync_decoder failed");
		$finish;
	end

	// Stall the output in random bursts, none in the calm tail
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Check every accepted output item
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Drive one byte, with an optional gap, and wait for its acceptance
	task automatic send_byte(input logic [7:0] rx);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= rx;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_byte(rx);
		sent++;
	endtask

	// Drop valid and hold until every queued tilt has come out
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Pick a payload byte, leaning toward header values now and then
	function automatic logic [7:0] payload_byte();
		case ($urandom_range(0, 9))
			0:       return ifsd_pkg::HEADER_FIRST;
			1:       return ifsd_pkg::HEADER_SECOND;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Send a header followed by random frame contents
	task automatic send_frame(input bit double_header);
		if (double_header)
			send_byte(ifsd_pkg::HEADER_FIRST);
		send_byte(ifsd_pkg::HEADER_FIRST);
		send_byte(ifsd_pkg::HEADER_SECOND);
		for (int k = 2; k < FRAME_LEN; k++)
			send_byte(payload_byte());
	endtask

	initial begin
		logic [7:0] directed[$];
		logic [7:0] rx;
		int         pick;
		int         rand_start;
		bit         drained;

		sb       = new();
		calm     = 1'b0;
		sent     = 0;
		drained  = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Broken header, then a doubled header into a frame with Y at raw
		// zero, X at raw full scale and a header pattern in the payload
		directed = {ifsd_pkg::HEADER_FIRST, 8'h05,
			ifsd_pkg::HEADER_FIRST, ifsd_pkg::HEADER_FIRST, ifsd_pkg::HEADER_SECOND,
			8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
			ifsd_pkg::HEADER_FIRST, ifsd_pkg::HEADER_SECOND,
			ifsd_pkg::HEADER_FIRST, ifsd_pkg::HEADER_SECOND};
		// Y at raw full scale, X exactly at the zero-tilt offset
		directed = {directed, ifsd_pkg::HEADER_FIRST, ifsd_pkg::HEADER_SECOND,
			8'hFF, 8'hFF, 8'hFF, 8'hC0, 8'hC6, 8'h2D,
			8'h12, 8'h34, 8'h56, 8'h78};
		foreach (directed[i])
			send_byte(directed[i]);

		// Random traffic: mostly clean frames, some noise and broken headers
		rand_start = sent;
		while (sent - rand_start < RAND_BYTES) begin
			calm = (sent - rand_start >= RAND_BYTES - CALM_BYTES);
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				send_frame(1'b0);
			end else if (pick == 6) begin
				send_frame(1'b1);
			end else if (pick == 7) begin
				send_byte(ifsd_pkg::HEADER_FIRST);
				do rx = 8'($urandom_range(0, 255));
				while (rx == ifsd_pkg::HEADER_FIRST || rx == ifsd_pkg::HEADER_SECOND);
				send_byte(rx);
			end else begin
				repeat ($urandom_range(1, 6))
					send_byte(payload_byte());
			end
			// Hold the sender once midway until the output side is empty
			if (!drained && sent - rand_start >= RAND_BYTES / 2) begin
				drained = 1'b1;
				drain_results();
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d bytes incl. broken and doubled headers; checked %0d tilt items",
			sent, sb.matched);
		$display("Mismatches or stray items: %0d", sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_inclinometer_frame_sync_decoder passed");
		else
			$display("tb_inclinometer_frame_sync_decoder failed");
		$finish;
	end

endmodule
